FILE: rtl/vsaot_pkg.sv
// ----------------------------------------------------------------------------
// Vital-sign alarm onset tracker package
// Shared constants, codes and types for the onset tracker and its compare unit.
// ----------------------------------------------------------------------------
package vsaot_pkg;

    localparam int DEVICE_COUNT = 16;
    localparam int RULE_COUNT   = 6;
    localparam int DEV_W        = 4;
    localparam int STORE_DEPTH  = DEVICE_COUNT * RULE_COUNT;
    localparam int SLOT_W       = $clog2(STORE_DEPTH);

    localparam int TIME_W  = 48;
    localparam int ONSET_W = 47;
    localparam int DIFF_W  = TIME_W + 1;
    localparam int ALU_W   = TIME_W + 2;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  HEART_LOW_RST  = 8'd50;
    localparam logic [7:0]  HEART_HIGH_RST = 8'd120;
    localparam logic [9:0]  OXYGEN_LOW_RST = 10'd920;
    localparam logic [6:0]  BATTERY_LOW_RST = 7'd20;
    localparam logic [15:0] STALE_LIMIT_RST = 16'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEART_LOW   = 3'd0,
        CFG_HEART_HIGH  = 3'd1,
        CFG_OXYGEN_LOW  = 3'd2,
        CFG_BATTERY_LOW = 3'd3,
        CFG_STALE_LIMIT = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KIND_HR_LOW  = 3'd0,
        KIND_HR_HIGH = 3'd1,
        KIND_OXYGEN  = 3'd2,
        KIND_BATTERY = 3'd3,
        KIND_OFFLINE = 3'd4,
        KIND_STALE   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_RULE,
        ST_READ,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [ALU_W-1:0] lhs;
        logic signed [ALU_W-1:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic signed [ALU_W-1:0] diff;
        logic                    lt;
    } t_alu_rsp;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [DEV_W-1:0] dev,
                                                   input logic [2:0] rule);
        return SLOT_W'(dev) * SLOT_W'(RULE_COUNT) + SLOT_W'(rule);
    endfunction

endpackage

FILE: rtl/vsaot_alu.sv
// ----------------------------------------------------------------------------
// Onset tracker compare unit
// Shared signed subtractor; the sign of the difference gives the less-than flag.
// ----------------------------------------------------------------------------
module vsaot_alu (
    input  vsaot_pkg::t_alu_req i_req,
    output vsaot_pkg::t_alu_rsp o_rsp
);

    logic signed [vsaot_pkg::ALU_W-1:0] diff;

    assign diff       = i_req.lhs - i_req.rhs;
    assign o_rsp.diff = diff;
    assign o_rsp.lt   = diff[vsaot_pkg::ALU_W-1];

endmodule

FILE: rtl/vital_sign_alarm_onset_tracker.sv
// ----------------------------------------------------------------------------
// Vital-sign alarm onset tracker
// Checks six alarm rules per device report and tracks each alarm's onset time.
// ----------------------------------------------------------------------------
// Device reports enter on the slave stream; each active alarm leaves on the
// master stream as one request with its kind and severity in tuser, its onset
// time in tdata and tlast on the final alarm of the report. Thresholds are
// written through the configuration channel, which is always ready.
// A report for an absent or inactive device is taken without a rule walk and
// yields nothing. Any other report walks the six rules through one shared
// subtractor: a step for the time difference, a step per rule, one more step
// per alarm whose onset is already stored (a registered read of the onset
// memory) and a closing step. Reports are not accepted while one is in
// progress.
// A stalled receiver holds the output register and, once the one-entry pending
// buffer is also full, the rule walk waits.
// Reset restores the default thresholds and clears every held-onset flag at
// once; the onset memory needs no clearing pass.
// ----------------------------------------------------------------------------
module vital_sign_alarm_onset_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // device_present, device_index, lifecycle_active, heart_valid, heart_rate,
    // oxygen_valid, oxygen_tenths, battery_valid, battery_pct, link_online,
    // last_seen_time, now_time
    input  logic [vsaot_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // onset_time
    output logic [vsaot_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // alarm_kind, alarm_critical
    output logic [vsaot_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vsaot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsaot_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [7:0]  r_hr_low;
    logic [7:0]  r_hr_high;
    logic [9:0]  r_ox_low;
    logic [6:0]  r_bat_low;
    logic [15:0] r_stale;

    vsaot_pkg::t_state r_state, n_state;
    vsaot_pkg::t_kind  r_rule;

    logic [vsaot_pkg::DEV_W-1:0]          r_dev;
    logic                                 r_hv, r_ov, r_bv, r_online;
    logic [7:0]                           r_hr;
    logic [9:0]                           r_ox;
    logic [6:0]                           r_bat;
    logic signed [vsaot_pkg::TIME_W-1:0]  r_seen, r_now;
    logic signed [vsaot_pkg::DIFF_W-1:0]  r_diff;

    logic                                 r_pend_valid;
    vsaot_pkg::t_kind                     r_pend_kind;
    logic [vsaot_pkg::ONSET_W-1:0]        r_pend_onset;

    logic                                 r_out_valid;
    vsaot_pkg::t_kind                     r_out_kind;
    logic                                 r_out_crit;
    logic [vsaot_pkg::ONSET_W-1:0]        r_out_onset;
    logic                                 r_out_last;

    logic [vsaot_pkg::STORE_DEPTH-1:0]    r_held, n_held;
    logic [vsaot_pkg::ONSET_W-1:0]        r_store [0:vsaot_pkg::STORE_DEPTH-1];
    logic [vsaot_pkg::ONSET_W-1:0]        r_rd_data;

    logic                          in_accept, in_present, in_lifecycle;
    logic [vsaot_pkg::DEV_W-1:0]   in_dev;
    logic                          out_free;
    logic [vsaot_pkg::SLOT_W-1:0]  slot;
    logic                          held_cur, act, stall, seen_never;
    logic [vsaot_pkg::ONSET_W-1:0] new_onset;
    vsaot_pkg::t_alu_req           alu_req;
    vsaot_pkg::t_alu_rsp           alu_rsp;

    logic push, push_last, pend_load_new, pend_load_rd;
    logic held_set, held_clr, mem_we, mem_re, rule_inc, diff_load;

    vsaot_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_s_tready   = (r_state == vsaot_pkg::ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign in_accept    = i_s_tvalid && o_s_tready;
    assign in_dev       = i_s_tdata[4:1];
    assign in_present   = i_s_tdata[0] &&
                          ({1'b0, in_dev} < (vsaot_pkg::DEV_W + 1)'(vsaot_pkg::DEVICE_COUNT));
    assign in_lifecycle = i_s_tdata[5];

    assign out_free   = !r_out_valid || i_m_tready;
    assign slot       = vsaot_pkg::slot_of(r_dev, r_rule);
    assign held_cur   = r_held[slot];
    assign seen_never = r_seen[vsaot_pkg::TIME_W-1] || (r_seen == '0);
    assign new_onset  = r_now[vsaot_pkg::TIME_W-1] ? '0 : r_now[vsaot_pkg::ONSET_W-1:0];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_onset};
    assign o_m_tuser  = {r_out_crit, r_out_kind};
    assign o_m_tlast  = r_out_last;

    always_comb begin
        alu_req.lhs = '0;
        alu_req.rhs = '0;
        if (r_state == vsaot_pkg::ST_DIFF) begin
            alu_req.lhs = vsaot_pkg::ALU_W'(r_now);
            alu_req.rhs = vsaot_pkg::ALU_W'(r_seen);
        end else begin
            unique case (r_rule)
                vsaot_pkg::KIND_HR_LOW: begin
                    alu_req.lhs = vsaot_pkg::ALU_W'(r_hr);
                    alu_req.rhs = vsaot_pkg::ALU_W'(r_hr_low);
                end
                vsaot_pkg::KIND_HR_HIGH: begin
                    alu_req.lhs = vsaot_pkg::ALU_W'(r_hr_high);
                    alu_req.rhs = vsaot_pkg::ALU_W'(r_hr);
                end
                vsaot_pkg::KIND_OXYGEN: begin
                    alu_req.lhs = vsaot_pkg::ALU_W'(r_ox);
                    alu_req.rhs = vsaot_pkg::ALU_W'(r_ox_low);
                end
                vsaot_pkg::KIND_BATTERY: begin
                    alu_req.lhs = vsaot_pkg::ALU_W'(r_bat);
                    alu_req.rhs = vsaot_pkg::ALU_W'(r_bat_low);
                end
                vsaot_pkg::KIND_STALE: begin
                    alu_req.lhs = vsaot_pkg::ALU_W'(r_stale);
                    alu_req.rhs = vsaot_pkg::ALU_W'(r_diff);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        act = 1'b0;
        if (r_state != vsaot_pkg::ST_DIFF) begin
            unique case (r_rule)
                vsaot_pkg::KIND_HR_LOW:  act = r_hv && alu_rsp.lt;
                vsaot_pkg::KIND_HR_HIGH: act = r_hv && alu_rsp.lt;
                vsaot_pkg::KIND_OXYGEN:  act = r_ov && alu_rsp.lt;
                vsaot_pkg::KIND_BATTERY: act = r_bv && alu_rsp.lt;
                vsaot_pkg::KIND_OFFLINE: act = !r_online;
                vsaot_pkg::KIND_STALE:   act = seen_never || alu_rsp.lt;
                default:                 act = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vsaot_pkg::ST_IDLE: begin
                if (in_accept && in_present && in_lifecycle) begin
                    n_state = vsaot_pkg::ST_DIFF;
                end
            end
            vsaot_pkg::ST_DIFF: begin
                n_state = vsaot_pkg::ST_RULE;
            end
            vsaot_pkg::ST_RULE: begin
                if (!stall) begin
                    if (act && held_cur) begin
                        n_state = vsaot_pkg::ST_READ;
                    end else if (r_rule == vsaot_pkg::KIND_STALE) begin
                        n_state = vsaot_pkg::ST_FLUSH;
                    end
                end
            end
            vsaot_pkg::ST_READ: begin
                if (r_rule == vsaot_pkg::KIND_STALE) begin
                    n_state = vsaot_pkg::ST_FLUSH;
                end else begin
                    n_state = vsaot_pkg::ST_RULE;
                end
            end
            vsaot_pkg::ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = vsaot_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vsaot_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        stall         = 1'b0;
        push          = 1'b0;
        push_last     = 1'b0;
        pend_load_new = 1'b0;
        pend_load_rd  = 1'b0;
        held_set      = 1'b0;
        held_clr      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rule_inc      = 1'b0;
        diff_load     = 1'b0;
        unique case (r_state)
            vsaot_pkg::ST_DIFF: begin
                diff_load = 1'b1;
            end
            vsaot_pkg::ST_RULE: begin
                stall = act && r_pend_valid && !out_free;
                if (!stall) begin
                    push          = act && r_pend_valid;
                    held_set      = act && !held_cur;
                    held_clr      = !act;
                    mem_we        = act && !held_cur;
                    mem_re        = act && held_cur;
                    pend_load_new = act && !held_cur;
                    rule_inc      = !(act && held_cur);
                end
            end
            vsaot_pkg::ST_READ: begin
                pend_load_rd = 1'b1;
                rule_inc     = 1'b1;
            end
            vsaot_pkg::ST_FLUSH: begin
                push_last = r_pend_valid && out_free;
            end
            default: begin
                stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hr_low  <= vsaot_pkg::HEART_LOW_RST;
            r_hr_high <= vsaot_pkg::HEART_HIGH_RST;
            r_ox_low  <= vsaot_pkg::OXYGEN_LOW_RST;
            r_bat_low <= vsaot_pkg::BATTERY_LOW_RST;
            r_stale   <= vsaot_pkg::STALE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (vsaot_pkg::t_cfg_reg'(i_cfg_index))
                vsaot_pkg::CFG_HEART_LOW:   r_hr_low  <= i_cfg_data[7:0];
                vsaot_pkg::CFG_HEART_HIGH:  r_hr_high <= i_cfg_data[7:0];
                vsaot_pkg::CFG_OXYGEN_LOW:  r_ox_low  <= i_cfg_data[9:0];
                vsaot_pkg::CFG_BATTERY_LOW: r_bat_low <= i_cfg_data[6:0];
                vsaot_pkg::CFG_STALE_LIMIT: r_stale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vsaot_pkg::ST_IDLE;
            r_rule  <= vsaot_pkg::KIND_HR_LOW;
        end else begin
            r_state <= n_state;
            if (diff_load) begin
                r_rule <= vsaot_pkg::KIND_HR_LOW;
            end else if (rule_inc && (r_rule != vsaot_pkg::KIND_STALE)) begin
                r_rule <= vsaot_pkg::t_kind'(r_rule + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dev    <= in_dev;
            r_hv     <= i_s_tdata[6];
            r_hr     <= i_s_tdata[14:7];
            r_ov     <= i_s_tdata[15];
            r_ox     <= i_s_tdata[25:16];
            r_bv     <= i_s_tdata[26];
            r_bat    <= i_s_tdata[33:27];
            r_online <= i_s_tdata[34];
            r_seen   <= i_s_tdata[82:35];
            r_now    <= i_s_tdata[130:83];
        end
        if (diff_load) begin
            r_diff <= alu_rsp.diff[vsaot_pkg::DIFF_W-1:0];
        end
    end

    always_comb begin
        n_held = r_held;
        if (in_accept && in_present && !in_lifecycle) begin
            for (int r = 0; r < vsaot_pkg::RULE_COUNT; r++) begin
                n_held[vsaot_pkg::slot_of(in_dev, 3'(r))] = 1'b0;
            end
        end
        if (held_set) begin
            n_held[slot] = 1'b1;
        end else if (held_clr) begin
            n_held[slot] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[slot] <= new_onset;
        end
        if (mem_re) begin
            r_rd_data <= r_store[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (pend_load_new || pend_load_rd) begin
            r_pend_valid <= 1'b1;
        end else if (push || push_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_load_new) begin
            r_pend_kind  <= r_rule;
            r_pend_onset <= new_onset;
        end else if (pend_load_rd) begin
            r_pend_kind  <= r_rule;
            r_pend_onset <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push || push_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push || push_last) begin
            r_out_kind  <= r_pend_kind;
            r_out_crit  <= (r_pend_kind == vsaot_pkg::KIND_OXYGEN);
            r_out_onset <= r_pend_onset;
            r_out_last  <= push_last;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pend_valid)
        else $error("A pending alarm is left over while the tracker is idle.");

    a_read_follows_fetch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vsaot_pkg::ST_READ) |-> $past(mem_re))
        else $error("Onset read data is used without a preceding memory read.");

    a_write_sets_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_held[$past(slot)])
        else $error("An onset entry was written without its held flag being set.");

    a_push_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push || push_last) |-> (!r_out_valid || i_m_tready))
        else $error("An alarm request overwrote an output that was not taken.");
`endif

endmodule

FILE: tb/vsaot_alarm_checker.sv
// ----------------------------------------------------------------------------
// Alarm onset checker
// Watches the report, alarm and threshold channels of the onset tracker. It
// predicts the alarms of every accepted report from its own copy of the
// thresholds and onset store, and compares each accepted alarm with the
// oldest prediction.
// ----------------------------------------------------------------------------
module vsaot_alarm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [vsaot_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [vsaot_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  logic [vsaot_pkg::OUT_TUSER_W-1:0]   i_m_tuser,
    input  logic                                i_m_tlast,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [vsaot_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vsaot_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [4:0]                          spare;
        logic signed [vsaot_pkg::TIME_W-1:0] now_s;
        logic signed [vsaot_pkg::TIME_W-1:0] seen;
        logic                                online;
        logic [6:0]                          bat;
        logic                                bat_ok;
        logic [9:0]                          ox;
        logic                                ox_ok;
        logic [7:0]                          hr;
        logic                                hr_ok;
        logic                                active;
        logic [vsaot_pkg::DEV_W-1:0]         dev;
        logic                                present;
    } t_report_bus;

    typedef struct packed {
        vsaot_pkg::t_kind                  kind;
        logic                              critical;
        logic [vsaot_pkg::OUT_TDATA_W-1:0] onset;
        logic                              last;
    } t_alarm;

    logic [7:0]  heart_low;
    logic [7:0]  heart_high;
    logic [9:0]  oxygen_low;
    logic [6:0]  battery_low;
    logic [15:0] stale_limit;

    logic [vsaot_pkg::STORE_DEPTH-1:0] onset_held;
    logic [vsaot_pkg::ONSET_W-1:0]     onset_mem [vsaot_pkg::STORE_DEPTH];

    t_alarm alarm_q[$];
    int     fail_count;
    int     checked_count;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;

    task automatic predict_alarms(input t_report_bus rep);
        logic [vsaot_pkg::RULE_COUNT-1:0] fire;
        t_alarm                           fired[$];
        t_alarm                           a;
        int                               base;
        if (!rep.present) return;
        base = int'(rep.dev) * vsaot_pkg::RULE_COUNT;
        if (!rep.active) begin
            for (int r = 0; r < vsaot_pkg::RULE_COUNT; r++) onset_held[base + r] = 1'b0;
            return;
        end
        fire[vsaot_pkg::KIND_HR_LOW]  = rep.hr_ok && (rep.hr < heart_low);
        fire[vsaot_pkg::KIND_HR_HIGH] = rep.hr_ok && (rep.hr > heart_high);
        fire[vsaot_pkg::KIND_OXYGEN]  = rep.ox_ok && (rep.ox < oxygen_low);
        fire[vsaot_pkg::KIND_BATTERY] = rep.bat_ok && (rep.bat < battery_low);
        fire[vsaot_pkg::KIND_OFFLINE] = !rep.online;
        fire[vsaot_pkg::KIND_STALE]   = (rep.seen <= 0) || ((rep.now_s > rep.seen) &&
            ((longint'(rep.now_s) - longint'(rep.seen)) > longint'(stale_limit)));
        for (int r = 0; r < vsaot_pkg::RULE_COUNT; r++) begin
            if (!fire[r]) begin
                onset_held[base + r] = 1'b0;
            end else begin
                if (!onset_held[base + r]) begin
                    onset_held[base + r] = 1'b1;
                    onset_mem[base + r] = (rep.now_s > 0) ?
                        rep.now_s[vsaot_pkg::ONSET_W-1:0] : '0;
                end
                a.kind     = vsaot_pkg::t_kind'(r);
                a.critical = (vsaot_pkg::t_kind'(r) == vsaot_pkg::KIND_OXYGEN);
                a.onset    = vsaot_pkg::OUT_TDATA_W'(onset_mem[base + r]);
                a.last     = 1'b0;
                fired      = {fired, a};
            end
        end
        if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
        alarm_q = {alarm_q, fired};
    endtask

    task automatic note_failure(input bit unexpected, input t_alarm want, input t_alarm got);
        if (fail_count < MAX_REPORTED) begin
            if (unexpected)
                $display("ERROR: alarm with none pending: kind %0d crit %0b onset %0d last %0b",
                         got.kind, got.critical, got.onset, got.last);
            else
                $display("ERROR: alarm %0d: expected kind %0d crit %0b onset %0d last %0b, %s",
                         checked_count, want.kind, want.critical, want.onset, want.last,
                         $sformatf("got kind %0d crit %0b onset %0d last %0b",
                                   got.kind, got.critical, got.onset, got.last));
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_alarm got;
        t_alarm want;
        if (!i_rst_n) begin
            heart_low   = vsaot_pkg::HEART_LOW_RST;
            heart_high  = vsaot_pkg::HEART_HIGH_RST;
            oxygen_low  = vsaot_pkg::OXYGEN_LOW_RST;
            battery_low = vsaot_pkg::BATTERY_LOW_RST;
            stale_limit = vsaot_pkg::STALE_LIMIT_RST;
            onset_held  = '0;
            alarm_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    vsaot_pkg::CFG_HEART_LOW:   heart_low   = i_cfg_data[7:0];
                    vsaot_pkg::CFG_HEART_HIGH:  heart_high  = i_cfg_data[7:0];
                    vsaot_pkg::CFG_OXYGEN_LOW:  oxygen_low  = i_cfg_data[9:0];
                    vsaot_pkg::CFG_BATTERY_LOW: battery_low = i_cfg_data[6:0];
                    vsaot_pkg::CFG_STALE_LIMIT: stale_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) predict_alarms(t_report_bus'(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.kind     = vsaot_pkg::t_kind'(i_m_tuser[2:0]);
                got.critical = i_m_tuser[3];
                got.onset    = i_m_tdata;
                got.last     = i_m_tlast;
                if (alarm_q.size() == 0) begin
                    note_failure(1'b1, got, got);
                end else begin
                    want = alarm_q.pop_front();
                    if (got !== want) note_failure(1'b0, want, got);
                end
                checked_count++;
            end
        end
        o_pending <= alarm_q.size();
    end

endmodule

FILE: tb/tb_vital_sign_alarm_onset_tracker.sv
// ----------------------------------------------------------------------------
// Vital-sign alarm onset tracker testbench
// Drives directed and random device reports through several threshold
// settings, with random idling and stalls on both streams, one long output
// hold and pauses until all alarms have drained. A separate checker predicts
// and compares every alarm; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_vital_sign_alarm_onset_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_REPORTS  = 74;
    localparam int IDLE_PERCENT   = 12;
    localparam logic [vsaot_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd6;
    localparam logic signed [vsaot_pkg::TIME_W-1:0] TIME_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [vsaot_pkg::TIME_W-1:0] TIME_MIN = 48'h8000_0000_0000;
    localparam logic signed [vsaot_pkg::TIME_W-1:0] TIME_ALL_ONES = '1;

    typedef struct packed {
        logic [4:0]                          spare;
        logic signed [vsaot_pkg::TIME_W-1:0] now_s;
        logic signed [vsaot_pkg::TIME_W-1:0] seen;
        logic                                online;
        logic [6:0]                          bat;
        logic                                bat_ok;
        logic [9:0]                          ox;
        logic                                ox_ok;
        logic [7:0]                          hr;
        logic                                hr_ok;
        logic                                active;
        logic [vsaot_pkg::DEV_W-1:0]         dev;
        logic                                present;
    } t_report;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [vsaot_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                              o_m_tvalid;
    logic                              m_tready = 1'b0;
    logic [vsaot_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [vsaot_pkg::OUT_TUSER_W-1:0] o_m_tuser;
    logic                              o_m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [vsaot_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [vsaot_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending_alarms;
    int alarms_checked;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit long_hold  = 1'b0;
    int idle_cycles = 0;
    int reports_sent = 0;
    int directed_sent = 0;
    int writes_done = 0;
    longint wall_clock = 1000;

    int heart_low_lim   = vsaot_pkg::HEART_LOW_RST;
    int heart_high_lim  = vsaot_pkg::HEART_HIGH_RST;
    int oxygen_low_lim  = vsaot_pkg::OXYGEN_LOW_RST;
    int battery_low_lim = vsaot_pkg::BATTERY_LOW_RST;
    int stale_lim       = vsaot_pkg::STALE_LIMIT_RST;

    vital_sign_alarm_onset_tracker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    vsaot_alarm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_alarms),
        .o_checked    (alarms_checked)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= !(rx_idle_en && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("vital_sign_alarm_onset_tracker: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_report(input t_report r);
        if (tx_idle_en) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vsaot_pkg::IN_TDATA_W'(r);
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        reports_sent++;
    endtask

    // Lowers the report valid, waits for every predicted alarm and lets any
    // report that raises no alarm finish its rule walk.
    task automatic drain_alarms();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_alarms != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vsaot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vsaot_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        writes_done++;
        unique case (idx)
            vsaot_pkg::CFG_HEART_LOW:   heart_low_lim   = value[7:0];
            vsaot_pkg::CFG_HEART_HIGH:  heart_high_lim  = value[7:0];
            vsaot_pkg::CFG_OXYGEN_LOW:  oxygen_low_lim  = value[9:0];
            vsaot_pkg::CFG_BATTERY_LOW: battery_low_lim = value[6:0];
            vsaot_pkg::CFG_STALE_LIMIT: stale_lim       = value;
            default: ;
        endcase
    endtask

    task automatic program_limits(input logic [15:0] hl, input logic [15:0] hh,
                                  input logic [15:0] ox, input logic [15:0] bat,
                                  input logic [15:0] stale);
        drain_alarms();
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        write_reg(vsaot_pkg::CFG_HEART_LOW, hl);
        write_reg(vsaot_pkg::CFG_HEART_HIGH, hh);
        write_reg(vsaot_pkg::CFG_OXYGEN_LOW, ox);
        write_reg(vsaot_pkg::CFG_BATTERY_LOW, bat);
        write_reg(vsaot_pkg::CFG_STALE_LIMIT, stale);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_report quiet_report(input int dev,
                                             input logic signed [vsaot_pkg::TIME_W-1:0] t);
        t_report r;
        r = '0;
        r.present = 1'b1;
        r.dev     = vsaot_pkg::DEV_W'(dev);
        r.active  = 1'b1;
        r.hr_ok   = 1'b1;
        r.hr      = 8'd80;
        r.ox_ok   = 1'b1;
        r.ox      = 10'd980;
        r.bat_ok  = 1'b1;
        r.bat     = 7'd90;
        r.online  = 1'b1;
        r.now_s   = t;
        r.seen    = t - 48'sd1;
        return r;
    endfunction

    function automatic int near_limit(input int limit, input int top_val);
        int v;
        if ($urandom_range(1) == 1) return $urandom_range(top_val);
        v = limit + int'($urandom_range(4)) - 2;
        return (v < 0) ? 0 : ((v > top_val) ? top_val : v);
    endfunction

    function automatic t_report random_report();
        t_report r;
        int      pick;
        r = '0;
        r.present = ($urandom_range(99) >= 4);
        r.dev     = vsaot_pkg::DEV_W'(($urandom_range(99) < 70) ? $urandom_range(3) :
                                                                $urandom_range(15));
        r.active  = ($urandom_range(99) >= 10);
        r.hr_ok   = ($urandom_range(99) >= 15);
        r.hr      = 8'(near_limit($urandom_range(1) ? heart_low_lim : heart_high_lim, 255));
        r.ox_ok   = ($urandom_range(99) >= 15);
        r.ox      = 10'(near_limit(oxygen_low_lim, 1000));
        r.bat_ok  = ($urandom_range(99) >= 15);
        r.bat     = 7'(near_limit(battery_low_lim, 100));
        r.online  = ($urandom_range(99) < 70);
        wall_clock += $urandom_range(40);
        r.now_s = ($urandom_range(99) < 6) ? vsaot_pkg::TIME_W'({$urandom, $urandom}) :
                                             vsaot_pkg::TIME_W'(wall_clock);
        pick = $urandom_range(99);
        if (pick < 8)
            r.seen = 48'sd0 - vsaot_pkg::TIME_W'($urandom_range(3));
        else if (pick < 14)
            r.seen = r.now_s + vsaot_pkg::TIME_W'($urandom_range(500, 1));
        else if (pick < 20)
            r.seen = vsaot_pkg::TIME_W'({$urandom, $urandom});
        else if (pick < 40)
            r.seen = r.now_s - vsaot_pkg::TIME_W'(stale_lim + $urandom_range(1));
        else
            r.seen = r.now_s - vsaot_pkg::TIME_W'($urandom_range(2 * stale_lim + 4));
        return r;
    endfunction

    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain_alarms();
            send_report(random_report());
        end
    endtask

    initial begin : stimulus
        t_report r;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = quiet_report(0, 100);
        r.present = 1'b0; r.hr = 8'd0; r.online = 1'b0; r.seen = '0;
        send_report(r);
        r = quiet_report(0, 100);
        r.hr = 8'd0; r.ox = 10'd0; r.bat = 7'd0; r.online = 1'b0; r.seen = '0;
        send_report(r);
        r = quiet_report(0, 200);
        r.hr = 8'd255; r.ox = 10'd0; r.bat = 7'd0; r.online = 1'b0; r.seen = '0;
        send_report(r);
        r = quiet_report(0, 250);
        r.active = 1'b0; r.hr = 8'd0; r.online = 1'b0;
        send_report(r);
        r = quiet_report(0, 300);
        r.hr = 8'd0; r.ox = 10'd0; r.bat = 7'd0; r.online = 1'b0; r.seen = '0;
        send_report(r);
        send_report(quiet_report(15, 5000));
        r = quiet_report(15, 5000);
        r.hr_ok = 1'b0; r.hr = 8'd0; r.ox_ok = 1'b0; r.ox = 10'd0;
        r.bat_ok = 1'b0; r.bat = 7'd0; r.seen = 48'sd4879;
        send_report(r);
        r.seen = 48'sd4880;
        send_report(r);
        r = quiet_report(14, 5000);
        r.seen = 48'sd6000; r.online = 1'b0;
        send_report(r);
        r = quiet_report(13, -48'sd5);
        r.online = 1'b0;
        send_report(r);
        r = quiet_report(12, TIME_MAX);
        r.seen = 48'sd1; r.hr = 8'd49; r.ox = 10'd919; r.bat = 7'd19;
        send_report(r);
        r = quiet_report(12, TIME_MIN);
        r.seen = TIME_MAX; r.hr = 8'd50; r.ox = 10'd920; r.bat = 7'd20;
        send_report(r);
        r.hr = 8'd121;
        send_report(r);
        r = quiet_report(11, TIME_ALL_ONES);
        r.seen = TIME_ALL_ONES; r.hr = 8'd120; r.ox = 10'd1000; r.bat = 7'd100;
        send_report(r);
        r = quiet_report(11, 48'sd7);
        r.seen = TIME_ALL_ONES; r.hr = 8'd0;
        send_report(r);
        r = quiet_report(10, 48'sd400);
        r.ox = 10'd0; r.bat_ok = 1'b0; r.bat = 7'd0;
        send_report(r);
        directed_sent = reports_sent;

        program_limits(16'hFFFF, 16'h00FF, 16'hFFE8, 16'hFF64, 16'hFFFF);
        long_hold = 1'b1;
        run_random(PHASE_REPORTS, -1);

        program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(PHASE_REPORTS, PHASE_REPORTS / 2);

        program_limits(16'($urandom_range(255)), 16'($urandom_range(255)),
                       16'($urandom_range(1000)), 16'($urandom_range(100)),
                       16'($urandom_range(65535)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(PHASE_REPORTS, -1);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        program_limits(16'(vsaot_pkg::HEART_LOW_RST), 16'(vsaot_pkg::HEART_HIGH_RST),
                       16'(vsaot_pkg::OXYGEN_LOW_RST), 16'(vsaot_pkg::BATTERY_LOW_RST),
                       vsaot_pkg::STALE_LIMIT_RST);
        run_random(PHASE_REPORTS, PHASE_REPORTS / 3);
        drain_alarms();

        $display("Summary: %0d reports (%0d directed), %0d alarms checked, %0d register writes.",
                 reports_sent, directed_sent, alarms_checked, writes_done);
        $display("Thresholds: defaults, maximum, zero, random, defaults; one long output hold.");
        if (fail_count == 0) begin
            $display("vital_sign_alarm_onset_tracker: match");
        end else begin
            $display("vital_sign_alarm_onset_tracker: mismatch");
        end
        $finish;
    end

endmodule
